FILE: rtl/core/frml_pkg.sv
// ----------------------------------------------------------------------------
// frml_pkg
// Shared types and constants for the frame rate meter and limiter.
// ----------------------------------------------------------------------------
package frml_pkg;

  // Payload field widths
  localparam int unsigned NOW_W     = 32;
  localparam int unsigned FPS_W     = 22;
  localparam int unsigned DELAY_W   = 10;
  localparam int unsigned FT_W      = 16;
  localparam int unsigned MAX_FPS_W = 10;

  // APB port
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  // Default averaging window
  localparam int unsigned WINDOW_SAMPLES_DEF = 10;

  // Arithmetic constants
  localparam int unsigned MS_PER_SEC     = 1000;
  localparam int unsigned FPS_SCALE      = MS_PER_SEC * 256;
  localparam int unsigned DEFAULT_FPS_Q8 = 60 * 256;
  localparam int unsigned FPS_Q8_MAX     = 4194303;
  localparam int unsigned FRAME_TIME_MAX = 65535;

  // Register reset values
  localparam logic                 LIMIT_ENABLE_RST = 1'b1;
  localparam logic [MAX_FPS_W-1:0] MAX_FPS_RST      = 10'd60;

  // Register indexes (byte address bit 2)
  localparam logic REG_LIMIT_ENABLE = 1'b0;
  localparam logic REG_MAX_FPS      = 1'b1;

  // Event kinds
  typedef enum logic {
    OP_BEGIN = 1'b0,
    OP_END   = 1'b1
  } frml_op_e;

  // Divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } frml_div_stat_t;

endpackage

FILE: rtl/core/frml_if.sv
// ----------------------------------------------------------------------------
// frml_if
// Valid/ready channels for frame events and for measurement results.
// ----------------------------------------------------------------------------
interface frml_in_if;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [frml_pkg::NOW_W-1:0] now_ms;

  modport source (output valid, output opcode, output now_ms, input ready);
  modport sink   (input valid, input opcode, input now_ms, output ready);
endinterface

interface frml_out_if;
  logic                         valid;
  logic                         ready;
  logic [frml_pkg::FPS_W-1:0]   fps_q8;
  logic [frml_pkg::DELAY_W-1:0] delay_ms;
  logic [frml_pkg::FT_W-1:0]    frame_time_ms;

  modport source (output valid, output fps_q8, output delay_ms, output frame_time_ms,
                  input ready);
  modport sink   (input valid, input fps_q8, input delay_ms, input frame_time_ms,
                  output ready);
endinterface

FILE: rtl/core/frml_div.sv
// ----------------------------------------------------------------------------
// frml_div
// Restoring divider, one quotient bit per cycle, shared by the sequencer.
// ----------------------------------------------------------------------------
module frml_div #(
  parameter int unsigned NUM_W = 22,
  parameter int unsigned DEN_W = 20
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [NUM_W-1:0]         num_i,
  input  logic [DEN_W-1:0]         den_i,
  output logic [NUM_W-1:0]         quo_o,
  output frml_pkg::frml_div_stat_t stat_o
);
  import frml_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_q;
  logic [DEN_W:0]   rem_q;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             fits;

  // trial subtract of the shifted partial remainder
  assign rem_sh  = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
  assign fits    = (rem_sh >= {1'b0, den_q});
  assign rem_sub = rem_sh - {1'b0, den_q};

  // control: bit counter and status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        cnt_q  <= CNT_W'(NUM_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // datapath: dividend shifts out as quotient shifts in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= fits ? rem_sub : rem_sh;
      quo_q <= {quo_q[NUM_W-2:0], fits};
    end
  end

  assign quo_o       = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

FILE: rtl/core/frame_rate_meter_limiter_unit.sv
// ----------------------------------------------------------------------------
// frame_rate_meter_limiter_unit
// Frame rate meter with moving-average window and optional rate limiter.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries frame events (opcode 0 = begin, 1 = end) with a ms timestamp.
//   A begin request only records its timestamp and gives no result. An end
//   request gives one result on out_o: averaged fps in Q8, the delay needed to
//   hold max_fps, and the saturated time since the previous end.
//   An end reads the filled window entries (up to WINDOW_SAMPLES) one per
//   cycle from the ring memory, then uses the bit-serial divider (dividend
//   22 bits wide for a window of 10) once for the rate, if the sum is not
//   zero, and once for the period 1000/max_fps, when limiting. Until the
//   result is handed to the output register, in_i is not ready.
//   One event at a time is in flight; in_i is ready whenever the sequencer is
//   idle, even while an earlier result still waits on out_o.
//   If out_o stalls, the finished result waits in the sequencer until the
//   output register is free.
//   Reset empties the window, clears the timestamps and sets limit_enable = 1,
//   max_fps = 60. Registers are written over APB at byte address 0 and 4.
// ----------------------------------------------------------------------------
module frame_rate_meter_limiter_unit #(
  parameter int unsigned WINDOW_SAMPLES = frml_pkg::WINDOW_SAMPLES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  frml_in_if.sink                             in_i,
  frml_out_if.source                          out_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [frml_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [frml_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [frml_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import frml_pkg::*;

  localparam int unsigned SUM_W = $clog2(WINDOW_SAMPLES * FRAME_TIME_MAX + 1);
  localparam int unsigned NUM_W = $clog2(FPS_SCALE * WINDOW_SAMPLES + 1);
  localparam int unsigned CNT_W = $clog2(WINDOW_SAMPLES + 1);
  localparam int unsigned POS_W = (WINDOW_SAMPLES > 1) ? $clog2(WINDOW_SAMPLES) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_FPS_WAIT,
    S_PER,
    S_PER_WAIT,
    S_OUT
  } state_e;

  state_e state_q;

  // configuration
  logic                 limit_enable_q;
  logic [MAX_FPS_W-1:0] max_fps_q;

  // event state
  logic [NOW_W-1:0]     start_time_q;
  logic [NOW_W-1:0]     prev_end_q;
  logic                 have_prev_q;
  logic [POS_W-1:0]     pos_q;
  logic [CNT_W-1:0]     fill_q;

  // working registers
  logic [NOW_W-1:0]     now_q;
  logic [FT_W-1:0]      elapsed_q;
  logic [CNT_W-1:0]     idx_q;
  logic [SUM_W-1:0]     sum_q;
  logic [FPS_W-1:0]     fps_q;
  logic [DELAY_W-1:0]   delay_q;

  // ring memory
  logic [FT_W-1:0]      ring_q [WINDOW_SAMPLES];
  logic [FT_W-1:0]      rd_data_q;
  logic                 rd_vld_q;
  logic                 rd_en;

  // shared divider
  logic                 div_start_q;
  logic [NUM_W-1:0]     div_num_q;
  logic [SUM_W-1:0]     div_den_q;
  logic [NUM_W-1:0]     div_quo;
  frml_div_stat_t       div_stat;

  // output register
  logic                 out_valid_q;
  logic [FPS_W-1:0]     out_fps_q;
  logic [DELAY_W-1:0]   out_delay_q;
  logic [FT_W-1:0]      out_ft_q;

  logic                 accept;
  logic                 end_req;
  logic [NOW_W-1:0]     end_diff;
  logic [FT_W-1:0]      elapsed_d;
  logic                 out_free;
  logic [DELAY_W-1:0]   period;
  logic [NOW_W-1:0]     duration;
  logic                 cfg_wr;
  logic                 sum_done;
  logic                 div_go;
  logic                 out_load;

  // request handshake
  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign end_req    = accept && (in_i.opcode == OP_END);

  // frame time since previous end, saturated
  assign end_diff  = in_i.now_ms - prev_end_q;
  always_comb begin
    if (!have_prev_q) begin
      elapsed_d = '0;
    end else if (end_diff > NOW_W'(FRAME_TIME_MAX)) begin
      elapsed_d = FT_W'(FRAME_TIME_MAX);
    end else begin
      elapsed_d = end_diff[FT_W-1:0];
    end
  end

  // delay from period and frame duration
  assign period   = DELAY_W'(div_quo);
  assign duration = now_q - start_time_q;

  assign rd_en    = (state_q == S_SUM) && (idx_q < fill_q);
  assign out_free = !out_valid_q || out_o.ready;

  // divider launch and output register load
  assign sum_done = (state_q == S_SUM) && !rd_en && !rd_vld_q;
  assign div_go   = (sum_done && (sum_q != '0))
                 || ((state_q == S_PER) && limit_enable_q && (max_fps_q != '0));
  assign out_load = (state_q == S_OUT) && out_free;

  // ring memory: write on frame end, sequential read while summing
  always_ff @(posedge clk_i) begin
    if (end_req) begin
      ring_q[pos_q] <= elapsed_d;
    end
    if (rd_en) begin
      rd_data_q <= ring_q[idx_q[POS_W-1:0]];
    end
  end

  // APB registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[2])
      REG_LIMIT_ENABLE: prdata = APB_DATA_W'(limit_enable_q);
      REG_MAX_FPS:      prdata = APB_DATA_W'(max_fps_q);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_enable_q <= LIMIT_ENABLE_RST;
      max_fps_q      <= MAX_FPS_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_LIMIT_ENABLE: limit_enable_q <= pwdata[0];
        REG_MAX_FPS:      max_fps_q      <= pwdata[MAX_FPS_W-1:0];
        default:          ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      start_time_q <= '0;
      prev_end_q   <= '0;
      have_prev_q  <= 1'b0;
      pos_q        <= '0;
      fill_q       <= '0;
      now_q        <= '0;
      elapsed_q    <= '0;
      idx_q        <= '0;
      sum_q        <= '0;
      fps_q        <= '0;
      delay_q      <= '0;
      rd_vld_q     <= 1'b0;
      div_start_q  <= 1'b0;
      div_num_q    <= '0;
      div_den_q    <= '0;
      out_valid_q  <= 1'b0;
      out_fps_q    <= '0;
      out_delay_q  <= '0;
      out_ft_q     <= '0;
    end else begin
      div_start_q <= div_go;
      rd_vld_q    <= rd_en;
      out_valid_q <= out_load || (out_valid_q && !out_o.ready);

      case (state_q)
        S_IDLE: begin
          if (accept && (in_i.opcode == OP_BEGIN)) begin
            start_time_q <= in_i.now_ms;
          end
          if (end_req) begin
            prev_end_q  <= in_i.now_ms;
            have_prev_q <= 1'b1;
            now_q       <= in_i.now_ms;
            elapsed_q   <= elapsed_d;
            pos_q       <= (pos_q == POS_W'(WINDOW_SAMPLES - 1)) ? '0 : pos_q + POS_W'(1);
            if (fill_q < CNT_W'(WINDOW_SAMPLES)) begin
              fill_q <= fill_q + CNT_W'(1);
            end
            idx_q   <= '0;
            sum_q   <= '0;
            state_q <= S_SUM;
          end
        end

        // accumulate the filled entries, one per cycle
        S_SUM: begin
          if (rd_en) begin
            idx_q <= idx_q + CNT_W'(1);
          end
          if (rd_vld_q) begin
            sum_q <= sum_q + SUM_W'(rd_data_q);
          end
          if (sum_done) begin
            if (sum_q == '0) begin
              fps_q   <= FPS_W'(DEFAULT_FPS_Q8);
              state_q <= S_PER;
            end else begin
              div_num_q <= NUM_W'(FPS_SCALE) * NUM_W'(fill_q);
              div_den_q <= sum_q;
              state_q   <= S_FPS_WAIT;
            end
          end
        end

        S_FPS_WAIT: begin
          if (div_stat.done) begin
            if (32'(div_quo) > 32'(FPS_Q8_MAX)) begin
              fps_q <= FPS_W'(FPS_Q8_MAX);
            end else begin
              fps_q <= FPS_W'(div_quo);
            end
            state_q <= S_PER;
          end
        end

        // period = 1000 / max_fps when limiting
        S_PER: begin
          if (limit_enable_q && (max_fps_q != '0)) begin
            div_num_q <= NUM_W'(MS_PER_SEC);
            div_den_q <= SUM_W'(max_fps_q);
            state_q   <= S_PER_WAIT;
          end else begin
            delay_q <= '0;
            state_q <= S_OUT;
          end
        end

        S_PER_WAIT: begin
          if (div_stat.done) begin
            if (NOW_W'(period) > duration) begin
              delay_q <= period - duration[DELAY_W-1:0];
            end else begin
              delay_q <= '0;
            end
            state_q <= S_OUT;
          end
        end

        // hand the result to the output register once it is free
        S_OUT: begin
          if (out_load) begin
            out_fps_q   <= fps_q;
            out_delay_q <= delay_q;
            out_ft_q    <= elapsed_q;
            state_q     <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  frml_div #(
    .NUM_W (NUM_W),
    .DEN_W (SUM_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .num_i   (div_num_q),
    .den_i   (div_den_q),
    .quo_o   (div_quo),
    .stat_o  (div_stat)
  );

  assign out_o.valid         = out_valid_q;
  assign out_o.fps_q8        = out_fps_q;
  assign out_o.delay_ms      = out_delay_q;
  assign out_o.frame_time_ms = out_ft_q;

endmodule

FILE: rtl/core/frml_chk.sv
// ----------------------------------------------------------------------------
// frml_chk
// Port-level checks for the frame rate meter and limiter.
// ----------------------------------------------------------------------------
module frml_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         in_opcode_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [frml_pkg::FPS_W-1:0]   out_fps_q8_i,
  input logic [frml_pkg::DELAY_W-1:0] out_delay_ms_i,
  input logic [frml_pkg::FT_W-1:0]    out_frame_time_ms_i
);
  import frml_pkg::*;

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_fps_q8_i)
      && $stable(out_delay_ms_i) && $stable(out_frame_time_ms_i))
    else $error("result changed while stalled");

  // a frame end occupies the sequencer
  a_end_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_opcode_i == OP_END) |=> !in_ready_i)
    else $error("ready after frame end request");

  // a frame begin never produces a result
  a_begin_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_opcode_i == OP_BEGIN) && !out_valid_i
      |=> !out_valid_i)
    else $error("result after frame begin");

  // delay never exceeds one second
  a_delay_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_delay_ms_i <= DELAY_W'(MS_PER_SEC))
    else $error("delay out of range");

endmodule

bind frame_rate_meter_limiter_unit frml_chk u_frml_chk (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_i.valid),
  .in_ready_i          (in_i.ready),
  .in_opcode_i         (in_i.opcode),
  .out_valid_i         (out_o.valid),
  .out_ready_i         (out_o.ready),
  .out_fps_q8_i        (out_o.fps_q8),
  .out_delay_ms_i      (out_o.delay_ms),
  .out_frame_time_ms_i (out_o.frame_time_ms)
);
